/* rtl/arpc_pkg.sv */
`default_nettype none

package arpc_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Field widths.
	localparam int IP_W       = 32;
	localparam int MAC_W      = 48;
	localparam int OPER_W     = 16;
	localparam int STATUS_W   = 3;
	localparam int SOP_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [IP_W-1:0]  IP_ZERO   = '0;
	localparam logic [IP_W-1:0]  IP_BCAST  = 32'hffff_ffff;
	localparam logic [MAC_W-1:0] MAC_BCAST = 48'hffff_ffff_ffff;

	// Received ARP operation codes.
	localparam logic [OPER_W-1:0] OPER_REQUEST = 16'd1;
	localparam logic [OPER_W-1:0] OPER_REPLY   = 16'd2;

	// Outgoing operation codes.
	localparam logic [SOP_W-1:0] SOP_NONE    = 2'd0;
	localparam logic [SOP_W-1:0] SOP_REQUEST = 2'd1;
	localparam logic [SOP_W-1:0] SOP_REPLY   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLY   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HIT     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REQUEST = 3'd5;
	localparam logic [STATUS_W-1:0] ST_PENDING = 3'd6;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DECIDE,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MAC_W-1:0]    mac;
		logic                sv;
		logic [SOP_W-1:0]    sop;
		logic [MAC_W-1:0]    dst;
		logic [MAC_W-1:0]    tmac;
		logic [IP_W-1:0]     tip;
	} res_t;

endpackage

`default_nettype wire

/* rtl/arp_responder_and_cache.sv */
`default_nettype none

// Channel   Handshake               Payload
// cfg       cfg_wr_en               cfg_index, cfg_wdata
// in        in_valid / in_ready     mode, frame_short, arp_oper, sender_mac, sender_ip,
//                                   target_ip, query_ip, no_wait
// out       out_valid / out_ready   status, resolved_mac, send_valid, send_oper,
//                                   send_dest_mac, send_target_mac, send_target_ip
//
// An item that needs a table lookup goes from its transfer through the decode, scan and
// decision steps to its result being loaded; the scan is run by the lookup sequencer,
// which reads one table entry per cycle through a single comparator. Items that need no
// lookup go from decode straight to the hold step. The block takes one item at a time.
// The result sits in an output register, so the next item can be taken while it waits.
// The asynchronous reset clears all control state and the used and resolved bits.

module arp_responder_and_cache (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           mode,
	input  wire logic                           frame_short,
	input  wire logic [arpc_pkg::OPER_W-1:0]     arp_oper,
	input  wire logic [arpc_pkg::MAC_W-1:0]      sender_mac,
	input  wire logic [arpc_pkg::IP_W-1:0]       sender_ip,
	input  wire logic [arpc_pkg::IP_W-1:0]       target_ip,
	input  wire logic [arpc_pkg::IP_W-1:0]       query_ip,
	input  wire logic                           no_wait,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [arpc_pkg::STATUS_W-1:0]        status,
	output logic [arpc_pkg::MAC_W-1:0]           resolved_mac,
	output logic                                send_valid,
	output logic [arpc_pkg::SOP_W-1:0]           send_oper,
	output logic [arpc_pkg::MAC_W-1:0]           send_dest_mac,
	output logic [arpc_pkg::MAC_W-1:0]           send_target_mac,
	output logic [arpc_pkg::IP_W-1:0]            send_target_ip
);

	import arpc_pkg::*;

	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

	// Configuration. The own MAC address is the sender hardware address of outgoing
	// packets, which the frame builder downstream fills in; no result field carries it,
	// so a write to its index is accepted and holds nothing here.
	logic [IP_W-1:0] own_ip_q;
	logic            link_q;

	// Captured input item.
	logic             mode_q;
	logic             short_q;
	logic [OPER_W-1:0] oper_q;
	logic [MAC_W-1:0] smac_q;
	logic [IP_W-1:0]  sip_q;
	logic [IP_W-1:0]  tip_q;
	logic [IP_W-1:0]  qip_q;
	logic             nowait_q;

	// Sequencer and lookup state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] scan_cnt_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [IP_W-1:0]  rd_ip_s1;
	logic [MAC_W-1:0] rd_mac_s1;
	logic             found_q;
	logic             found_res_q;
	logic [IDX_W-1:0] slot_q;
	logic [MAC_W-1:0] hit_mac_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_slot_q;
	logic [IP_W-1:0]  key_ip;
	logic             need_scan;

	// Table: valid bits in flops, addresses in memories.
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [TABLE_ENTRIES-1:0] resolved_q;
	logic [IP_W-1:0]          ip_mem  [TABLE_ENTRIES];
	logic [MAC_W-1:0]         mac_mem [TABLE_ENTRIES];
	logic                     ip_we;
	logic                     mac_we;

	// Result staging and output register.
	res_t res_d, res_q, out_q;
	logic out_valid_q;
	logic out_load;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			link_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OWN_IP:  own_ip_q <= cfg_wdata[IP_W-1:0];
				CFG_OWN_MAC: ;
				CFG_LINK:    link_q <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	// Input capture on transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q   <= mode;
			short_q  <= frame_short;
			oper_q   <= arp_oper;
			smac_q   <= sender_mac;
			sip_q    <= sender_ip;
			tip_q    <= target_ip;
			qip_q    <= query_ip;
			nowait_q <= no_wait;
		end
	end

	// A received reply looks up its sender IP; a query looks up the queried IP unless it
	// is the zero or the broadcast address, which resolve without the table.
	assign key_ip = mode_q ? qip_q : sip_q;
	assign need_scan = mode_q ? ((qip_q != IP_ZERO) && (qip_q != IP_BCAST))
	                          : (!short_q && (tip_q == own_ip_q) && (oper_q == OPER_REPLY));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: state_d = need_scan ? S_SCAN : S_HOLD;
			S_SCAN:   if (scan_cnt_q == SCAN_END) state_d = S_DECIDE;
			S_DECIDE: state_d = S_HOLD;
			S_HOLD:   if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs of the sequencer: handshake, read issue, table writes and the result.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_load = (state_q == S_HOLD) && (!out_valid_q || out_ready);
		rd_en    = (state_q == S_SCAN) && (scan_cnt_q != SCAN_END);
		ip_we    = 1'b0;
		mac_we   = 1'b0;
		res_d    = '0;
		case (state_q)
			S_DECODE: begin
				if (mode_q) begin
					res_d.status = ST_HIT;
					res_d.mac    = (qip_q == IP_ZERO) ? '0 : MAC_BCAST;
				end else if (!short_q && (tip_q == own_ip_q) && (oper_q == OPER_REQUEST)) begin
					res_d.status = ST_REPLY;
					res_d.sv     = 1'b1;
					res_d.sop    = SOP_REPLY;
					res_d.dst    = smac_q;
					res_d.tmac   = smac_q;
					res_d.tip    = sip_q;
				end else begin
					res_d.status = ST_IGNORED;
				end
			end
			S_DECIDE: begin
				if (!mode_q) begin
					// A reply without a matching entry creates nothing.
					if (found_q) begin
						res_d.status = ST_UPDATED;
						mac_we       = 1'b1;
					end
				end else if (found_q && found_res_q) begin
					res_d.status = ST_HIT;
					res_d.mac    = hit_mac_q;
				end else if (!link_q || nowait_q) begin
					res_d.status = ST_MISS;
				end else if (found_q) begin
					res_d.status = ST_PENDING;
				end else if (free_found_q) begin
					res_d.status = ST_REQUEST;
					res_d.sv     = 1'b1;
					res_d.sop    = SOP_REQUEST;
					res_d.dst    = MAC_BCAST;
					res_d.tip    = qip_q;
					ip_we        = 1'b1;
				end else begin
					res_d.status = ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// Scan counter and read pipeline valid.
	assign rd_addr = scan_cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q   <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == S_DECODE) begin
			scan_cnt_q   <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			// The first used entry with a matching IP wins, as does the first free one.
			if (rd_vld_s1 && !found_q && used_q[rd_idx_s1] && (rd_ip_s1 == key_ip)) begin
				found_q <= 1'b1;
			end
			if (rd_vld_s1 && !free_found_q && !used_q[rd_idx_s1]) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if ((state_q == S_SCAN) && rd_vld_s1 && !found_q && used_q[rd_idx_s1]
		    && (rd_ip_s1 == key_ip)) begin
			slot_q      <= rd_idx_s1;
			found_res_q <= resolved_q[rd_idx_s1];
			hit_mac_q   <= rd_mac_s1;
		end
		if ((state_q == S_SCAN) && rd_vld_s1 && !free_found_q && !used_q[rd_idx_s1]) begin
			free_slot_q <= rd_idx_s1;
		end
	end

	// Address memories: one registered read per cycle during the scan, one write at the
	// decision step.
	always_ff @(posedge clk) begin
		if (ip_we) begin
			ip_mem[free_slot_q] <= qip_q;
		end
		if (rd_en) begin
			rd_ip_s1 <= ip_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mac_we) begin
			mac_mem[slot_q] <= smac_q;
		end
		if (rd_en) begin
			rd_mac_s1 <= mac_mem[rd_addr];
		end
	end

	// Used and resolved bits. A new entry starts pending; a reply resolves it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			resolved_q <= '0;
		end else begin
			if (ip_we) begin
				used_q[free_slot_q]     <= 1'b1;
				resolved_q[free_slot_q] <= 1'b0;
			end
			if (mac_we) begin
				resolved_q[slot_q] <= 1'b1;
			end
		end
	end

	// Result staging, loaded at the step that settles the outcome.
	always_ff @(posedge clk) begin
		if ((state_q == S_DECODE) || (state_q == S_DECIDE)) begin
			res_q <= res_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign resolved_mac    = out_q.mac;
	assign send_valid      = out_q.sv;
	assign send_oper       = out_q.sop;
	assign send_dest_mac   = out_q.dst;
	assign send_target_mac = out_q.tmac;
	assign send_target_ip  = out_q.tip;

`ifndef NO_ASSERTIONS
	// Only a table entry that is in use can be resolved.
	a_resolved_used: assert property (@(posedge clk) disable iff (!arst_n)
		(resolved_q & ~used_q) == '0)
		else $error("resolved bit set on an unused table entry");

	// An insertion never lands on an entry that is already in use.
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		ip_we |-> !used_q[free_slot_q])
		else $error("new entry written over a used entry");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in progress");

	// An outgoing packet goes with a reply or a request status only.
	a_send_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid |-> (status == ST_REPLY || status == ST_REQUEST))
		else $error("packet sent with a status that sends nothing");
`endif

endmodule

`default_nettype wire
